// ===== rtl/accel_tilt_motion_event_reporter_unit_macros.svh =====
// Assertion macros for the accelerometer tilt and motion event reporter.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ACCEL_TILT_MOTION_EVENT_REPORTER_UNIT_MACROS_SVH
`define ACCEL_TILT_MOTION_EVENT_REPORTER_UNIT_MACROS_SVH

// Check a property in the same cycle.
`define ATMER_ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a consequent in the same cycle as the antecedent.
`define ATMER_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after the antecedent.
`define ATMER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/atmer_pkg.sv =====
// Shared types, constants and tables of the tilt and motion event reporter.
// No dependencies.
package atmer_pkg;

  localparam int ACCEL_BITS   = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int FIELD_W   = 16;
  localparam int ACC_EXT_W = (ACCEL_BITS > FIELD_W) ? ACCEL_BITS : FIELD_W;
  localparam int THR_W     = 18;
  localparam int SUM_W     = ACCEL_BITS + 2;
  localparam int CMP_W     = (SUM_W > THR_W) ? SUM_W : THR_W;
  localparam int PRESCALE  = 8;
  localparam int CW        = ACCEL_BITS + 11;
  localparam int ZW        = 28;
  localparam int ZFRAC     = 16;
  localparam int TILT_W    = 12;
  localparam int STEP_W    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int ATAN_IDX_W = 5;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  localparam logic signed [ZW-1:0] Z_900   = ZW'(900 * 65536);
  localparam logic signed [ZW-1:0] Z_M900  = ZW'(-900 * 65536);
  localparam logic signed [ZW-1:0] Z_1800  = ZW'(1800 * 65536);
  localparam logic signed [TILT_W-1:0] TILT_MAX = 12'sd1800;
  localparam logic signed [TILT_W-1:0] TILT_MIN = -12'sd1800;

  localparam logic [THR_W-1:0] MOVED_THR_RESET  = THR_W'(400);
  localparam logic [THR_W-1:0] SHAKEN_THR_RESET = THR_W'(2000);

  localparam logic [4:0] PRESS_ALL_MASK = 5'h1f;
  localparam logic [4:0] PRESS_BTN_MASK = 5'h18;
  localparam int FLAG_MOVED  = 5;
  localparam int FLAG_SHAKEN = 6;

  typedef enum logic {
    REG_MOVED_THR  = 1'b0,
    REG_SHAKEN_THR = 1'b1
  } reg_idx_e;

  typedef logic signed [ACCEL_BITS-1:0] accel_t;

  typedef struct packed {
    logic              mode;
    logic [2:0]        port_levels;
    logic              button_a_level;
    logic              button_b_level;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [6:0]               event_flags;
    logic [1:0]               buttons_held;
    logic signed [TILT_W-1:0] tilt_x;
    logic signed [TILT_W-1:0] tilt_y;
  } out_item_t;

  typedef struct packed {
    logic              take;
    logic              prep;
    logic              step;
    logic              load_y;
    logic              publish;
    logic [STEP_W-1:0] step_idx;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] i);
    case (i)
      5'd0:    return ZW'(29491200);
      5'd1:    return ZW'(17409672);
      5'd2:    return ZW'(9198793);
      5'd3:    return ZW'(4669451);
      5'd4:    return ZW'(2343786);
      5'd5:    return ZW'(1173036);
      5'd6:    return ZW'(586661);
      5'd7:    return ZW'(293348);
      5'd8:    return ZW'(146676);
      5'd9:    return ZW'(73339);
      5'd10:   return ZW'(36669);
      5'd11:   return ZW'(18335);
      5'd12:   return ZW'(9167);
      5'd13:   return ZW'(4584);
      5'd14:   return ZW'(2292);
      5'd15:   return ZW'(1146);
      5'd16:   return ZW'(573);
      5'd17:   return ZW'(286);
      5'd18:   return ZW'(143);
      5'd19:   return ZW'(72);
      5'd20:   return ZW'(36);
      5'd21:   return ZW'(18);
      5'd22:   return ZW'(9);
      5'd23:   return ZW'(4);
      default: return '0;
    endcase
  endfunction

  function automatic accel_t take_accel(input logic signed [FIELD_W-1:0] f);
    logic [ACC_EXT_W-1:0] e;
    e = ACC_EXT_W'($unsigned(f));
    return accel_t'(e[ACCEL_BITS-1:0]);
  endfunction

endpackage

// ===== rtl/atmer_ctrl.sv =====
// Sequencer of the tilt and motion event reporter.
// Depends on atmer_pkg; drives the datapath through cmd_t.
module atmer_ctrl
  import atmer_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_mode_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PREP   = 6'b000010,
    ST_RUN_X  = 6'b000100,
    ST_LOAD_Y = 6'b001000,
    ST_RUN_Y  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    cmd_o.step_idx = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (in_mode_i) state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = ST_RUN_X;
      end
      ST_RUN_X: begin
        cmd_o.step = 1'b1;
        if (cnt_q == LAST_STEP) begin
          cnt_d   = '0;
          state_d = ST_LOAD_Y;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_LOAD_Y: begin
        cmd_o.load_y = 1'b1;
        state_d      = ST_RUN_Y;
      end
      ST_RUN_Y: begin
        cmd_o.step = 1'b1;
        if (cnt_q == LAST_STEP) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/atmer_datapath.sv =====
// Datapath of the tilt and motion event reporter: event state, motion sum,
// shared CORDIC rotation stage and output register. Depends on atmer_pkg.
module atmer_datapath
  import atmer_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  in_item_t         in_data_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [THR_W-1:0] cfg_wdata_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o
);

  function automatic logic signed [TILT_W-1:0] to_tenths(
    input logic signed [ZW-1:0] z,
    input logic                 flip
  );
    logic                     neg;
    logic [ZW-1:0]            mag;
    logic [ZW-ZFRAC-1:0]      q;
    logic signed [TILT_W-1:0] qc;
    neg = z[ZW-1];
    mag = neg ? ZW'(-z) : ZW'(z);
    q   = mag[ZW-1:ZFRAC];
    qc  = (TILT_W'(q) > $unsigned(TILT_MAX)) ? TILT_MAX : TILT_W'(q);
    return (neg ^ flip) ? -qc : qc;
  endfunction

  logic [THR_W-1:0]      moved_thr_q, shaken_thr_q;
  logic [6:0]            sticky_q, sticky_d;
  logic [4:0]            prev_pressed_q, prev_pressed_d;
  accel_t                prev_acc_q [3];
  accel_t                acc_q [3];
  logic [1:0]            held_q;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic signed [CW-1:0]  cx_q, cx_d, cy_q, cy_d;
  logic signed [ZW-1:0]  cz_q, cz_d;
  logic signed [TILT_W-1:0] tilt_x_q;
  logic                  out_valid_q;
  out_item_t             out_data_q;

  logic [4:0]            cur_pressed, press_mask;
  logic signed [CW-1:0]  ya, xa, x_ld, y_ld, dx, dy;
  logic signed [ZW-1:0]  z_ld, atan_v;

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

  assign cur_pressed = {~in_data_i.button_b_level, ~in_data_i.button_a_level,
                        ~in_data_i.port_levels};
  assign press_mask  = in_data_i.mode ? PRESS_BTN_MASK : PRESS_ALL_MASK;

  always_comb begin
    sticky_d       = sticky_q;
    prev_pressed_d = prev_pressed_q;
    if (cmd_i.take) begin
      sticky_d[4:0]  = sticky_q[4:0] | (cur_pressed & ~prev_pressed_q & press_mask);
      prev_pressed_d = (prev_pressed_q & ~press_mask) | (cur_pressed & press_mask);
    end else if (cmd_i.load_y) begin
      if (CMP_W'(sum_q) >= CMP_W'(moved_thr_q))  sticky_d[FLAG_MOVED]  = 1'b1;
      if (CMP_W'(sum_q) >= CMP_W'(shaken_thr_q)) sticky_d[FLAG_SHAKEN] = 1'b1;
    end else if (cmd_i.publish) begin
      sticky_d = '0;
    end
  end

  always_comb begin
    logic signed [ACCEL_BITS:0] diff;
    logic [ACCEL_BITS:0]        mag;
    sum_d = '0;
    for (int i = 0; i < 3; i++) begin
      diff  = (ACCEL_BITS + 1)'(acc_q[i]) - (ACCEL_BITS + 1)'(prev_acc_q[i]);
      mag   = diff[ACCEL_BITS] ? $unsigned(-diff) : $unsigned(diff);
      sum_d = sum_d + SUM_W'(mag);
    end
  end

  // Fold the vector into the right half plane; axis cases end with y at zero.
  always_comb begin
    ya   = CW'(cmd_i.load_y ? acc_q[1] : acc_q[0]);
    xa   = -CW'(acc_q[2]);
    x_ld = xa;
    y_ld = ya;
    z_ld = '0;
    if (ya == '0) begin
      y_ld = '0;
      z_ld = xa[CW-1] ? Z_1800 : '0;
    end else if (xa == '0) begin
      y_ld = '0;
      z_ld = ya[CW-1] ? Z_M900 : Z_900;
    end else if (xa[CW-1]) begin
      if (!ya[CW-1]) begin
        x_ld = ya;
        y_ld = -xa;
        z_ld = Z_900;
      end else begin
        x_ld = -ya;
        y_ld = xa;
        z_ld = Z_M900;
      end
    end
  end

  assign dx     = cy_q >>> cmd_i.step_idx;
  assign dy     = cx_q >>> cmd_i.step_idx;
  assign atan_v = atan_entry(ATAN_IDX_W'(cmd_i.step_idx));

  always_comb begin
    cx_d = cx_q;
    cy_d = cy_q;
    cz_d = cz_q;
    if (cmd_i.prep || cmd_i.load_y) begin
      cx_d = x_ld <<< PRESCALE;
      cy_d = y_ld <<< PRESCALE;
      cz_d = z_ld;
    end else if (cmd_i.step && (cy_q != '0)) begin
      if (!cy_q[CW-1]) begin
        cx_d = cx_q + dx;
        cy_d = cy_q - dy;
        cz_d = cz_q + atan_v;
      end else begin
        cx_d = cx_q - dx;
        cy_d = cy_q + dy;
        cz_d = cz_q - atan_v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moved_thr_q    <= MOVED_THR_RESET;
      shaken_thr_q   <= SHAKEN_THR_RESET;
      sticky_q       <= '0;
      prev_pressed_q <= '0;
      for (int i = 0; i < 3; i++) prev_acc_q[i] <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_MOVED_THR:  moved_thr_q  <= cfg_wdata_i;
          REG_SHAKEN_THR: shaken_thr_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      sticky_q       <= sticky_d;
      prev_pressed_q <= prev_pressed_d;
      if (cmd_i.prep) begin
        for (int i = 0; i < 3; i++) prev_acc_q[i] <= acc_q[i];
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_data_i.mode) begin
      acc_q[0] <= take_accel(in_data_i.accel_x);
      acc_q[1] <= take_accel(in_data_i.accel_y);
      acc_q[2] <= take_accel(in_data_i.accel_z);
      held_q   <= {~in_data_i.button_b_level, ~in_data_i.button_a_level};
    end
    if (cmd_i.prep) sum_q <= sum_d;
    cx_q <= cx_d;
    cy_q <= cy_d;
    cz_q <= cz_d;
    if (cmd_i.load_y) tilt_x_q <= to_tenths(cz_q, 1'b0);
    if (cmd_i.publish) begin
      out_data_q.event_flags  <= sticky_q;
      out_data_q.buttons_held <= held_q;
      out_data_q.tilt_x       <= tilt_x_q;
      out_data_q.tilt_y       <= to_tenths(cz_q, 1'b1);
    end
  end

endmodule

// ===== rtl/accel_tilt_motion_event_reporter_unit.sv =====
// Top level of the tilt and motion event reporter.
// Depends on atmer_pkg, atmer_ctrl, atmer_datapath and the assertion macros.
//
// A pin tick (mode 0) is taken while idle and gives no result. A sample
// (mode 1) goes through PREP, RUN_X, LOAD_Y, RUN_Y and DONE and is then
// published into the result register, after which the sequencer returns to
// idle and can take the next transaction. One datapath stage runs one
// CORDIC micro-rotation per cycle, first for tilt X and then for tilt Y,
// and no new transaction is taken during that run. A finished result
// waits in the output register while pin ticks keep being accepted; a
// second sample holds at its end until that register is free.
// No clearing pass after reset.
`include "accel_tilt_motion_event_reporter_unit_macros.svh"
module accel_tilt_motion_event_reporter_unit
  import atmer_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [THR_W-1:0] cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;

  atmer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  atmer_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `ATMER_ASSERT_NOW(a_cmd_exclusive, $onehot0({cmd.take, cmd.prep, cmd.step, cmd.load_y, cmd.publish}), "datapath commands overlap")
  `ATMER_ASSERT_NEXT(a_publish_valid, cmd.publish, out_valid_o && in_ready_o, "publish did not load result or return to idle")
  `ATMER_ASSERT_IMPL(a_publish_free, cmd.publish, !out_valid_o || out_ready_i, "result overwritten while pending")
  `ATMER_ASSERT_IMPL(a_tilt_range, out_valid_o, (out_data_o.tilt_x <= TILT_MAX) && (out_data_o.tilt_x >= TILT_MIN) && (out_data_o.tilt_y <= TILT_MAX) && (out_data_o.tilt_y >= TILT_MIN), "tilt out of range")

endmodule
